// File: hw/rtl/smeu_pkg.sv
// shared types, codes and widths of the stack machine execute unit
`default_nettype none

package smeu_pkg;

    localparam int KIND_W  = 4;
    localparam int DATA_W  = 32;
    localparam int VIDX_W  = 8;
    localparam int DEPTH_W = 7;
    localparam int INDEX_W = 16;
    localparam int TIME_W  = 32;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int NUM_VARS_DEF    = 256;

    localparam logic [KIND_W-1:0] K_PUSH   = 4'd0;
    localparam logic [KIND_W-1:0] K_ADD    = 4'd1;
    localparam logic [KIND_W-1:0] K_SUB    = 4'd2;
    localparam logic [KIND_W-1:0] K_MUL    = 4'd3;
    localparam logic [KIND_W-1:0] K_READ   = 4'd4;
    localparam logic [KIND_W-1:0] K_WRITE  = 4'd5;
    localparam logic [KIND_W-1:0] K_JUMP   = 4'd6;
    localparam logic [KIND_W-1:0] K_JUMPZ  = 4'd7;
    localparam logic [KIND_W-1:0] K_ASSIGN = 4'd8;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] operand_value;
        logic [VIDX_W-1:0]        var_index;
        logic                     target_exists;
        logic                     target_empty;
        logic                     is_last;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
        logic [INDEX_W-1:0]       instr_index;
        logic                     redirect;
        logic                     running;
        logic                     bad_jump;
        logic                     overflow;
        logic [TIME_W-1:0]        step_time;
    } res_t;

    typedef struct packed {
        logic              en;
        logic [VIDX_W-1:0] idx;
        logic [DATA_W-1:0] data;
    } var_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/smeu_var_mem.sv
// variable store: synchronous ram with clearing sweep and write-to-read forwarding
`default_nettype none

module smeu_var_mem
    import smeu_pkg::*;
#(
    parameter int NUM_VARS = NUM_VARS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    output logic                   busy,
    input  wire logic              rd_en,
    input  wire logic [VIDX_W-1:0] rd_idx,
    output logic [DATA_W-1:0]      rd_data,
    input  wire var_wr_t           wr
);

    localparam int VAW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

    logic [DATA_W-1:0] var_mem [NUM_VARS];

    logic              busy_reg;
    logic [VAW-1:0]    clr_cnt_reg;
    logic [DATA_W-1:0] mem_q_reg;
    logic              rd_ok_reg;
    logic              fwd_reg;
    logic [DATA_W-1:0] fwd_data_reg;

    logic              wr_ok;
    logic              rd_ok;
    logic              we;
    logic [VAW-1:0]    waddr;
    logic [DATA_W-1:0] wdata;

    assign wr_ok = ({24'd0, wr.idx} < 32'(NUM_VARS));
    assign rd_ok = ({24'd0, rd_idx} < 32'(NUM_VARS));

    always_comb begin
        if (busy_reg) begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = '0;
        end else begin
            we    = wr.en && wr_ok;
            waddr = VAW'(wr.idx);
            wdata = wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            var_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            mem_q_reg    <= var_mem[VAW'(rd_idx)];
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
            rd_ok_reg   <= 1'b0;
            fwd_reg     <= 1'b0;
        end else begin
            if (busy_reg) begin
                clr_cnt_reg <= clr_cnt_reg + VAW'(1);
                if (clr_cnt_reg == VAW'(NUM_VARS - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
            if (rd_en) begin
                rd_ok_reg <= rd_ok;
                // a write landing at the read edge is not seen by the ram read
                fwd_reg   <= wr.en && wr_ok && (wr.idx == rd_idx);
            end
        end
    end

    assign busy    = busy_reg;
    assign rd_data = !rd_ok_reg ? '0 : (fwd_reg ? fwd_data_reg : mem_q_reg);

endmodule

`default_nettype wire

// File: hw/rtl/smeu_core.sv
// execute core: top two stack entries in registers, the rest in a ram, plus control state
`default_nettype none

module smeu_core
    import smeu_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire item_t             item,
    input  wire logic [DATA_W-1:0] var_rdata,
    output var_wr_t                var_wr,
    output res_t                   res
);

    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);

    logic [DATA_W-1:0] stk_mem [STACK_DEPTH];

    logic [DATA_W-1:0]  t0_reg, t0_next;
    logic [DATA_W-1:0]  t1_reg, t1_next;
    logic [DW-1:0]      d_reg, d_next;
    logic               run_reg, run_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [TIME_W-1:0]  time_reg, time_next;

    logic [DATA_W-1:0] stk_q_reg;
    logic              fwd_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic [DATA_W-1:0] below;

    logic              full;
    logic              take;
    logic              is_jump;
    logic              redirect, bad_jump, overflow;
    logic              spill;
    logic [DATA_W-1:0] push_v;
    logic              do_push;
    logic [DATA_W-1:0] prod;
    logic              var_we;
    logic [DATA_W-1:0] var_wd;

    logic              spill_we;
    logic [SAW-1:0]    waddr;
    logic [SAW-1:0]    raddr;
    logic [DW-1:0]     d_eff;

    // entry just under t1, prefetched for every depth
    assign below = fwd_reg ? fwd_data_reg : stk_q_reg;
    assign full  = (d_reg == DW'(STACK_DEPTH));
    assign prod  = t1_reg * t0_reg;

    always_comb begin
        t0_next   = t0_reg;
        t1_next   = t1_reg;
        d_next    = d_reg;
        run_next  = run_reg;
        idx_next  = idx_reg;
        time_next = time_reg;
        redirect  = 1'b0;
        bad_jump  = 1'b0;
        overflow  = 1'b0;
        spill     = 1'b0;
        take      = 1'b0;
        do_push   = 1'b0;
        push_v    = '0;
        var_we    = 1'b0;
        var_wd    = '0;
        is_jump   = (item.kind == K_JUMP) || (item.kind == K_JUMPZ);

        if (item.kind == K_ASSIGN) begin
            var_we = 1'b1;
            var_wd = item.operand_value;
        end else if (run_reg && item.kind <= K_JUMPZ) begin
            time_next = time_reg + TIME_W'(1);
            unique case (item.kind) inside
                K_PUSH: begin
                    do_push = 1'b1;
                    push_v  = item.operand_value;
                end
                K_ADD, K_SUB, K_MUL: begin
                    if (d_reg >= DW'(2)) begin
                        if (item.kind == K_ADD) begin
                            t0_next = t1_reg + t0_reg;
                        end else if (item.kind == K_SUB) begin
                            t0_next = t1_reg - t0_reg;
                        end else begin
                            t0_next = prod;
                        end
                        t1_next = below;
                        d_next  = d_reg - DW'(1);
                    end else if (d_reg == DW'(1)) begin
                        if (item.kind == K_ADD) begin
                            t0_next = t0_reg;
                        end else if (item.kind == K_SUB) begin
                            t0_next = '0 - t0_reg;
                        end else begin
                            t0_next = '0;
                        end
                    end else begin
                        do_push = 1'b1;
                        push_v  = '0;
                    end
                end
                K_READ: begin
                    do_push = 1'b1;
                    push_v  = var_rdata;
                end
                K_WRITE: begin
                    var_we = 1'b1;
                    if (d_reg != '0) begin
                        var_wd  = t0_reg;
                        t0_next = t1_reg;
                        t1_next = below;
                        d_next  = d_reg - DW'(1);
                    end
                end
                K_JUMP: begin
                    take = 1'b1;
                end
                default: begin
                    take     = (d_reg == '0) || (t0_reg == '0);
                    idx_next = idx_reg + INDEX_W'(1);
                end
            endcase

            if (do_push) begin
                if (full) begin
                    overflow = 1'b1;
                end else begin
                    t0_next = push_v;
                    t1_next = t0_reg;
                    d_next  = d_reg + DW'(1);
                    spill   = (d_reg >= DW'(2));
                end
            end

            if (is_jump && take) begin
                if (item.target_exists) begin
                    idx_next = '0;
                    redirect = 1'b1;
                    if (item.target_empty) begin
                        run_next = 1'b0;
                    end
                end else begin
                    run_next = 1'b0;
                    bad_jump = 1'b1;
                end
            end else begin
                if (!is_jump) begin
                    idx_next = idx_reg + INDEX_W'(1);
                end
                if (item.is_last) begin
                    run_next = 1'b0;
                end
            end
        end
    end

    assign spill_we = fire && spill;
    assign waddr    = SAW'(d_reg - DW'(2));
    assign d_eff    = fire ? d_next : d_reg;
    assign raddr    = (d_eff >= DW'(3)) ? SAW'(d_eff - DW'(3)) : '0;

    always_ff @(posedge aclk) begin
        if (spill_we) begin
            stk_mem[waddr] <= t1_reg;
        end
        stk_q_reg    <= stk_mem[raddr];
        fwd_data_reg <= t1_reg;
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            t0_reg <= t0_next;
            t1_reg <= t1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg    <= '0;
            run_reg  <= 1'b1;
            idx_reg  <= '0;
            time_reg <= '0;
            fwd_reg  <= 1'b0;
        end else begin
            if (fire) begin
                d_reg    <= d_next;
                run_reg  <= run_next;
                idx_reg  <= idx_next;
                time_reg <= time_next;
            end
            // a spill into the entry being prefetched bypasses the ram
            fwd_reg <= spill_we && (waddr == raddr);
        end
    end

    assign var_wr.en   = fire && var_we;
    assign var_wr.idx  = item.var_index;
    assign var_wr.data = var_wd;

    assign res.top_value   = (d_next != '0) ? t0_next : '0;
    assign res.depth       = DEPTH_W'(d_next);
    assign res.instr_index = idx_next;
    assign res.redirect    = redirect;
    assign res.running     = run_next;
    assign res.bad_jump    = bad_jump;
    assign res.overflow    = overflow;
    assign res.step_time   = time_next;

endmodule

`default_nettype wire

// File: hw/rtl/smeu_out_buf.sv
// two-entry result buffer: output register plus skid slot
`default_nettype none

module smeu_out_buf
    import smeu_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire res_t push_data,
    output logic      room,
    output logic      m_valid,
    input  wire logic m_ready,
    output res_t      m_data
);

    logic head_valid_reg, head_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t head_reg;
    res_t skid_reg;

    logic pop;
    logic head_load_new;
    logic head_load_skid;
    logic skid_load;

    assign pop = head_valid_reg && m_ready;

    always_comb begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_load_new   = 1'b0;
        head_load_skid  = 1'b0;
        skid_load       = 1'b0;
        if (skid_valid_reg) begin
            if (pop) begin
                head_load_skid  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!head_valid_reg || pop) begin
                head_load_new   = 1'b1;
                head_valid_next = 1'b1;
            end else begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            head_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (head_load_new) begin
            head_reg <= push_data;
        end else if (head_load_skid) begin
            head_reg <= skid_reg;
        end
        if (skid_load) begin
            skid_reg <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign room    = !skid_valid_reg;
    assign m_valid = head_valid_reg;
    assign m_data  = head_reg;

endmodule

`default_nettype wire

// File: hw/rtl/stack_machine_execute_unit.sv
// throughput: one instruction per cycle while results have room, held by single-cycle execute
// variable read into the ex register, then execute over the stack ram into the result buffer
// the two-entry result buffer keeps accepting while one result waits downstream
// reset: stack empty, machine running, index and time zero
// after reset the variable ram is cleared one entry a cycle, with s_ready low until every entry is clear
`default_nettype none

module stack_machine_execute_unit
    import smeu_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int NUM_VARS    = NUM_VARS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [KIND_W-1:0]        s_kind,
    input  wire logic signed [DATA_W-1:0] s_operand_value,
    input  wire logic [VIDX_W-1:0]        s_var_index,
    input  wire logic                     s_target_exists,
    input  wire logic                     s_target_empty,
    input  wire logic                     s_is_last,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_top_value,
    output logic [DEPTH_W-1:0]            m_depth,
    output logic [INDEX_W-1:0]            m_instr_index,
    output logic                          m_redirect,
    output logic                          m_running,
    output logic                          m_bad_jump,
    output logic                          m_overflow,
    output logic [TIME_W-1:0]             m_step_time
);

    logic              ex_valid_reg, ex_valid_next;
    item_t             ex_item_reg;
    logic              ex_fire;
    logic              accept;
    logic              busy;
    logic              room;
    logic [DATA_W-1:0] var_rdata;
    var_wr_t           var_wr;
    res_t              res;
    res_t              m_data;

    assign ex_fire = ex_valid_reg && room;
    assign s_ready = !busy && (!ex_valid_reg || ex_fire);
    assign accept  = s_valid && s_ready;

    always_comb begin
        ex_valid_next = ex_valid_reg;
        if (accept) begin
            ex_valid_next = 1'b1;
        end else if (ex_fire) begin
            ex_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ex_item_reg.kind          <= s_kind;
            ex_item_reg.operand_value <= s_operand_value;
            ex_item_reg.var_index     <= s_var_index;
            ex_item_reg.target_exists <= s_target_exists;
            ex_item_reg.target_empty  <= s_target_empty;
            ex_item_reg.is_last       <= s_is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
        end else begin
            ex_valid_reg <= ex_valid_next;
        end
    end

    smeu_var_mem #(
        .NUM_VARS (NUM_VARS)
    ) u_var_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .busy    (busy),
        .rd_en   (accept),
        .rd_idx  (s_var_index),
        .rd_data (var_rdata),
        .wr      (var_wr)
    );

    smeu_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (ex_fire),
        .item      (ex_item_reg),
        .var_rdata (var_rdata),
        .var_wr    (var_wr),
        .res       (res)
    );

    smeu_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (ex_fire),
        .push_data (res),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_top_value   = m_data.top_value;
    assign m_depth       = m_data.depth;
    assign m_instr_index = m_data.instr_index;
    assign m_redirect    = m_data.redirect;
    assign m_running     = m_data.running;
    assign m_bad_jump    = m_data.bad_jump;
    assign m_overflow    = m_data.overflow;
    assign m_step_time   = m_data.step_time;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// self-checking bench for the stack machine execute unit: directed table, random programs, halt
module tb_top
    import smeu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM     = 1800;
    localparam int N_PHASES     = 4;
    localparam int HALTED_TAIL  = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int WATCHDOG     = 3000;
    localparam int SETTLE       = 20;
    localparam int IDLE_PCT [N_PHASES]  = '{0, 68, 0, 6};
    localparam int STALL_PCT [N_PHASES] = '{0, 0, 68, 6};

    // kinds above host assign are undefined and must be ignored
    localparam logic [KIND_W-1:0] K_UNDEF_LO = K_ASSIGN + 4'd1;
    localparam logic [KIND_W-1:0] K_UNDEF_HI = 4'hF;

    typedef enum int {MIX_NORMAL, MIX_FILL, MIX_DRAIN} mix_t;
    typedef enum int {HALT_LAST, HALT_BAD_JUMP, HALT_EMPTY_TARGET, HALT_JUMPZ_LAST} halt_cause_t;

    typedef struct {
        bit    typed;
        item_t instr;
        res_t  want;
    } open_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [KIND_W-1:0]        s_kind = '0;
    logic signed [DATA_W-1:0] s_operand_value = '0;
    logic [VIDX_W-1:0]        s_var_index = '0;
    logic                     s_target_exists = 1'b0;
    logic                     s_target_empty = 1'b0;
    logic                     s_is_last = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_top_value;
    logic [DEPTH_W-1:0]       m_depth;
    logic [INDEX_W-1:0]       m_instr_index;
    logic                     m_redirect;
    logic                     m_running;
    logic                     m_bad_jump;
    logic                     m_overflow;
    logic [TIME_W-1:0]        m_step_time;

    // machine state as the bench believes it to be
    logic [DATA_W-1:0]  stack_mem [STACK_DEPTH_DEF];
    int                 stack_level = 0;
    logic [DATA_W-1:0]  var_mem [NUM_VARS_DEF];
    bit                 running_now = 1'b1;
    logic [INDEX_W-1:0] next_index = '0;
    logic [TIME_W-1:0]  instant = '0;

    res_t      pending_states [$];
    open_row_t open_rows [$];
    int        err_cnt = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    logic      hold_tog = 1'b0;

    stack_machine_execute_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_operand_value (s_operand_value),
        .s_var_index     (s_var_index),
        .s_target_exists (s_target_exists),
        .s_target_empty  (s_target_empty),
        .s_is_last       (s_is_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_top_value     (m_top_value),
        .m_depth         (m_depth),
        .m_instr_index   (m_instr_index),
        .m_redirect      (m_redirect),
        .m_running       (m_running),
        .m_bad_jump      (m_bad_jump),
        .m_overflow      (m_overflow),
        .m_step_time     (m_step_time)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic bit stack_push(logic [DATA_W-1:0] w);
        if (stack_level >= STACK_DEPTH_DEF) return 1'b0;
        stack_mem[stack_level] = w;
        stack_level++;
        return 1'b1;
    endfunction

    // advance the believed state by one instruction and return what the unit should report
    function automatic res_t step_machine(item_t it);
        res_t              r;
        logic [DATA_W-1:0] a, b, acc;
        bit                is_jump, take, redir, bad, ovf;
        redir = 1'b0;
        bad   = 1'b0;
        ovf   = 1'b0;
        take  = 1'b0;
        if (it.kind == K_ASSIGN) begin
            var_mem[it.var_index] = it.operand_value;
        end else if (running_now && it.kind <= K_JUMPZ) begin
            is_jump = (it.kind == K_JUMP) || (it.kind == K_JUMPZ);
            case (it.kind) inside
                K_PUSH: begin
                    ovf = !stack_push(it.operand_value);
                end
                K_ADD, K_SUB, K_MUL: begin
                    if (stack_level >= 2) begin
                        a = stack_mem[stack_level-1];
                        b = stack_mem[stack_level-2];
                        acc = (it.kind == K_ADD) ? b + a : (it.kind == K_SUB) ? b - a : b * a;
                        stack_level -= 2;
                    end else if (stack_level == 1) begin
                        // one element: add keeps it, sub negates it, mul clears it
                        a = stack_mem[0];
                        acc = (it.kind == K_ADD) ? a : (it.kind == K_SUB) ? -a : '0;
                        stack_level = 0;
                    end else begin
                        acc = '0;
                    end
                    ovf = !stack_push(acc);
                end
                K_READ: begin
                    ovf = !stack_push(var_mem[it.var_index]);
                end
                K_WRITE: begin
                    acc = '0;
                    if (stack_level > 0) begin
                        stack_level--;
                        acc = stack_mem[stack_level];
                    end
                    var_mem[it.var_index] = acc;
                end
                K_JUMP: begin
                    take = 1'b1;
                end
                default: begin
                    take = (stack_level == 0) || (stack_mem[stack_level-1] == '0);
                    next_index++;
                end
            endcase
            instant++;
            if (is_jump && take) begin
                if (it.target_exists) begin
                    next_index = '0;
                    redir = 1'b1;
                    if (it.target_empty) running_now = 1'b0;
                end else begin
                    running_now = 1'b0;
                    bad = 1'b1;
                end
            end else begin
                if (!is_jump) next_index++;
                if (it.is_last) running_now = 1'b0;
            end
        end
        r.top_value   = (stack_level > 0) ? stack_mem[stack_level-1] : '0;
        r.depth       = DEPTH_W'(stack_level);
        r.instr_index = next_index;
        r.redirect    = redir;
        r.running     = running_now;
        r.bad_jump    = bad;
        r.overflow    = ovf;
        r.step_time   = instant;
        return r;
    endfunction

    function automatic item_t instr(logic [KIND_W-1:0] k, logic [DATA_W-1:0] v,
                                    logic [VIDX_W-1:0] vi, bit ex, bit em, bit last);
        item_t it;
        it.kind          = k;
        it.operand_value = v;
        it.var_index     = vi;
        it.target_exists = ex;
        it.target_empty  = em;
        it.is_last       = last;
        return it;
    endfunction

    function automatic res_t outcome(logic [DATA_W-1:0] top, int dep, int ix, bit rd, bit run,
                                     bit bad, bit ov, int tm);
        res_t r;
        r.top_value   = top;
        r.depth       = DEPTH_W'(dep);
        r.instr_index = INDEX_W'(ix);
        r.redirect    = rd;
        r.running     = run;
        r.bad_jump    = bad;
        r.overflow    = ov;
        r.step_time   = TIME_W'(tm);
        return r;
    endfunction

    task automatic add_row(input bit typed, input item_t it, input res_t want);
        open_row_t row;
        row.typed = typed;
        row.instr = it;
        row.want  = want;
        open_rows.insert(open_rows.size(), row);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (r < 55) return K_PUSH;
                if (r < 90) return K_READ;
                if (r < 95) return K_JUMPZ;
                return K_ASSIGN;
            end
            MIX_DRAIN: begin
                if (r < 20) return K_ADD;
                if (r < 40) return K_SUB;
                if (r < 55) return K_MUL;
                if (r < 85) return K_WRITE;
                if (r < 92) return K_JUMPZ;
                return K_PUSH;
            end
            default: begin
                if (r < 20) return K_PUSH;
                if (r < 28) return K_ADD;
                if (r < 36) return K_SUB;
                if (r < 44) return K_MUL;
                if (r < 54) return K_READ;
                if (r < 64) return K_WRITE;
                if (r < 70) return K_JUMP;
                if (r < 80) return K_JUMPZ;
                if (r < 92) return K_ASSIGN;
                return K_UNDEF_LO + KIND_W'($urandom_range(0, K_UNDEF_HI - K_UNDEF_LO));
            end
        endcase
    endfunction

    // while the machine runs, steer the control bits away from anything that would halt it
    function automatic item_t keep_running(item_t it);
        bit taken;
        if (!running_now) return it;
        taken = (it.kind == K_JUMP) ||
                (it.kind == K_JUMPZ && (stack_level == 0 || stack_mem[stack_level-1] == '0));
        if (taken) begin
            it.target_exists = 1'b1;
            it.target_empty  = 1'b0;
        end else if (it.kind <= K_JUMPZ) begin
            it.is_last = 1'b0;
        end
        return it;
    endfunction

    function automatic item_t random_instr(mix_t mix);
        item_t it;
        it.kind          = pick_kind(mix);
        it.operand_value = pick_word();
        it.var_index     = $urandom_range(0, 1) ? VIDX_W'($urandom_range(0, 7))
                                                : VIDX_W'($urandom_range(0, 255));
        it.target_exists = 1'($urandom_range(0, 1));
        it.target_empty  = 1'($urandom_range(0, 1));
        it.is_last       = 1'($urandom_range(0, 1));
        return keep_running(it);
    endfunction

    task automatic send_instr(input item_t it, input bit typed = 1'b0, input res_t want = '0);
        res_t predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_kind          <= it.kind;
        s_operand_value <= it.operand_value;
        s_var_index     <= it.var_index;
        s_target_exists <= it.target_exists;
        s_target_empty  <= it.target_empty;
        s_is_last       <= it.is_last;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predicted = step_machine(it);
        pending_states.insert(pending_states.size(), typed ? want : predicted);
    endtask

    task automatic flag(input string what, input logic [DATA_W-1:0] want, got);
        err_cnt++;
        $display("%0t: %s expected %h got %h", $time, what, want, got);
    endtask

    task automatic check_result(input res_t want);
        if (m_top_value !== want.top_value) flag("top_value", want.top_value, m_top_value);
        if (m_depth !== want.depth) flag("depth", want.depth, m_depth);
        if (m_instr_index !== want.instr_index)
            flag("instr_index", want.instr_index, m_instr_index);
        if (m_redirect !== want.redirect) flag("redirect", want.redirect, m_redirect);
        if (m_running !== want.running) flag("running", want.running, m_running);
        if (m_bad_jump !== want.bad_jump) flag("bad_jump", want.bad_jump, m_bad_jump);
        if (m_overflow !== want.overflow) flag("overflow", want.overflow, m_overflow);
        if (m_step_time !== want.step_time) flag("step_time", want.step_time, m_step_time);
    endtask

    // result side: check each beat, stall at random, and take one long hold-off on request
    initial begin
        int   hold_left;
        logic seen_tog;
        hold_left = 0;
        seen_tog  = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_states.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result beat with nothing expected", $time);
                end else begin
                    check_result(pending_states.pop_front());
                end
            end
            if (hold_tog != seen_tog) begin
                seen_tog  = hold_tog;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        mix_t        mix;
        halt_cause_t cause;
        foreach (var_mem[i]) var_mem[i] = '0;
        foreach (stack_mem[i]) stack_mem[i] = '0;

        add_row(1'b1, instr(K_ADD, 0, 0, 0, 0, 0), outcome(0, 1, 1, 0, 1, 0, 0, 1));
        add_row(1'b1, instr(K_WRITE, 0, 3, 0, 0, 0), outcome(0, 0, 2, 0, 1, 0, 0, 2));
        // jumpz on an empty stack is taken
        add_row(1'b1, instr(K_JUMPZ, 0, 0, 1, 0, 0), outcome(0, 0, 0, 1, 1, 0, 0, 3));
        add_row(1'b1, instr(K_PUSH, 32'h7FFF_FFFF, 0, 0, 0, 0),
                outcome(32'h7FFF_FFFF, 1, 1, 0, 1, 0, 0, 4));
        add_row(1'b1, instr(K_SUB, 0, 0, 0, 0, 0),
                outcome(32'h8000_0001, 1, 2, 0, 1, 0, 0, 5));
        add_row(1'b1, instr(K_PUSH, 32'h8000_0000, 0, 0, 0, 0),
                outcome(32'h8000_0000, 2, 3, 0, 1, 0, 0, 6));
        add_row(1'b1, instr(K_ADD, 0, 0, 0, 0, 0), outcome(1, 1, 4, 0, 1, 0, 0, 7));
        add_row(1'b1, instr(K_MUL, 0, 0, 0, 0, 0), outcome(0, 1, 5, 0, 1, 0, 0, 8));
        add_row(1'b1, instr(K_ASSIGN, 32'hDEAD_BEEF, 255, 1, 1, 1),
                outcome(0, 1, 5, 0, 1, 0, 0, 8));
        add_row(1'b0, instr(K_READ, 0, 255, 0, 0, 0), '0);
        add_row(1'b0, instr(K_JUMPZ, 0, 0, 0, 1, 0), '0);
        add_row(1'b0, instr(K_PUSH, 0, 0, 1, 1, 0), '0);
        // taken jumps ignore the last-instruction flag
        add_row(1'b1, instr(K_JUMPZ, 0, 0, 1, 0, 1), outcome(0, 3, 0, 1, 1, 0, 0, 12));
        add_row(1'b1, instr(K_JUMP, 32'hFFFF_FFFF, 0, 1, 0, 1),
                outcome(0, 3, 0, 1, 1, 0, 0, 13));
        add_row(1'b1, instr(K_UNDEF_HI, 32'hFFFF_FFFF, 255, 1, 1, 1),
                outcome(0, 3, 0, 0, 1, 0, 0, 13));
        add_row(1'b0, instr(K_UNDEF_LO, 0, 0, 0, 0, 0), '0);
        add_row(1'b0, instr(K_PUSH, 32'hFFFF_FFFF, 0, 0, 1, 0), '0);
        add_row(1'b0, instr(K_PUSH, 32'h8000_0000, 0, 0, 0, 0), '0);
        add_row(1'b0, instr(K_MUL, 0, 0, 0, 0, 0), '0);
        add_row(1'b0, instr(K_SUB, 0, 0, 0, 0, 0), '0);
        add_row(1'b0, instr(K_WRITE, 0, 0, 0, 0, 0), '0);
        add_row(1'b0, instr(K_READ, 0, 0, 0, 0, 0), '0);
        add_row(1'b0, instr(K_READ, 0, 200, 0, 0, 0), '0);
        add_row(1'b0, instr(K_ASSIGN, 32'h1234_5678, 7, 0, 0, 0), '0);
        add_row(1'b0, instr(K_READ, 0, 7, 0, 0, 0), '0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (open_rows[i]) send_instr(open_rows[i].instr, open_rows[i].typed, open_rows[i].want);

        mix = MIX_NORMAL;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            idle_pct = IDLE_PCT[ph];
            stall_pct <= STALL_PCT[ph];
            // long receiver hold-off while beats keep coming, to back the unit up
            if (ph == 0) hold_tog <= ~hold_tog;
            repeat (N_RANDOM / N_PHASES) begin
                if ($urandom_range(0, 99) == 0) mix = mix_t'($urandom_range(0, 2));
                send_instr(random_instr(mix));
            end
        end

        // the machine can halt only once per reset, so the halt comes last
        cause = halt_cause_t'($urandom_range(0, 3));
        case (cause)
            HALT_LAST:
                send_instr(instr(K_PUSH, pick_word(), 0, $urandom_range(0, 1),
                                 $urandom_range(0, 1), 1));
            HALT_BAD_JUMP:
                send_instr(instr(K_JUMP, pick_word(), 0, 0, $urandom_range(0, 1),
                                 $urandom_range(0, 1)));
            HALT_EMPTY_TARGET:
                send_instr(instr(K_JUMP, pick_word(), 0, 1, 1, $urandom_range(0, 1)));
            default: begin
                send_instr(instr(K_PUSH, 32'd5, 0, 0, 0, 0));
                send_instr(instr(K_JUMPZ, 0, 0, 0, $urandom_range(0, 1), 1));
            end
        endcase
        repeat (HALTED_TAIL) send_instr(random_instr(MIX_NORMAL));
        s_valid <= 1'b0;

        while (pending_states.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
